>>> sv/hrsl_pkg.sv
// Shared types and codes for the hash ring successor lookup block.
package hrsl_pkg;

    localparam int HASH_W   = 32;
    localparam int HOST_W   = 8;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 3;
    localparam int HELD_W   = 10;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_FULL   = 3'd2,
        ST_DUP    = 3'd3,
        ST_ABSENT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CMP   = 2'd1,
        S_APPLY = 2'd2
    } state_t;

    // Broadcast to every cell
    typedef struct packed {
        logic              cmp;     // compare key against held point
        logic              ins;     // open a slot and shift right
        logic              del;     // close the slot and shift left
        logic [HASH_W-1:0] hash;
        logic [HOST_W-1:0] host;
    } cmd_t;

    // Per-cell compare result, registered in the cell
    typedef struct packed {
        logic occ;  // cell holds a point
        logic lt;   // point hash < key
        logic le;   // point hash <= key
        logic eq;   // point hash == key
    } flags_t;

endpackage

>>> sv/hash_ring_successor_lookup.sv
// Top level of the hash ring successor lookup: control, cell chain and result register.
//
//  channel | direction | payload                          | handshake
//  --------+-----------+----------------------------------+--------------------
//  in      | to block  | opcode, hash_value, host_number  | in_valid / in_ready
//  out     | from block| mapped_host, status, points_held | out_valid / out_ready
//
//  Each beat goes through a compare cycle in which every cell checks its point
//  against the key, then an update cycle in which the cells shift and the
//  result is written to the result register. The next input beat is taken
//  during the update cycle.
//  Reset clears the point count and the control; the cells' points need none.
//  A full result register with out_ready low holds the update cycle and input.
module hash_ring_successor_lookup #(
    parameter int RING_POINTS = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hrsl_pkg::OPCODE_W-1:0]     opcode,
    input  logic [hrsl_pkg::HASH_W-1:0]       hash_value,
    input  logic [hrsl_pkg::HOST_W-1:0]       host_number,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hrsl_pkg::HOST_W-1:0]       mapped_host,
    output logic [hrsl_pkg::STATUS_W-1:0]     status,
    output logic [hrsl_pkg::HELD_W-1:0]       points_held
);

    localparam int CW = $clog2(RING_POINTS + 1);
    localparam int PW = hrsl_pkg::HELD_W;

    hrsl_pkg::state_t                  state_reg;
    hrsl_pkg::state_t                  state_next;
    logic [hrsl_pkg::OPCODE_W-1:0]     op_reg;
    logic [hrsl_pkg::HASH_W-1:0]       key_reg;
    logic [hrsl_pkg::HOST_W-1:0]       new_host_reg;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [hrsl_pkg::HOST_W-1:0]       mapped_reg;
    logic [hrsl_pkg::HOST_W-1:0]       mapped_next;
    logic [hrsl_pkg::STATUS_W-1:0]     status_reg;
    logic [hrsl_pkg::STATUS_W-1:0]     status_next;
    logic [PW-1:0]                     held_reg;
    logic [PW-1:0]                     held_next;
    logic [PW+CW-1:0]                  held_ext;

    logic                              in_fire;
    logic                              advance;
    logic                              present;
    logic                              full;
    logic                              any_sel;
    logic [hrsl_pkg::HOST_W-1:0]       sel_host;
    hrsl_pkg::cmd_t                    cmd;

    // chain wiring
    logic [hrsl_pkg::HASH_W-1:0]       cell_hash [RING_POINTS];
    logic [hrsl_pkg::HOST_W-1:0]       cell_host [RING_POINTS];
    hrsl_pkg::flags_t                  cell_flags [RING_POINTS];
    logic [RING_POINTS-1:0]            sel_vec;
    logic [RING_POINTS-1:0]            eq_vec;

    // Result register is free this cycle, so the update may go ahead
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == hrsl_pkg::S_IDLE) ||
                      ((state_reg == hrsl_pkg::S_APPLY) && advance);
    assign in_fire  = in_valid && in_ready;

    assign present = |eq_vec;
    assign full    = (count_reg >= CW'(RING_POINTS));

    always_comb
    begin
        cmd.cmp  = (state_reg == hrsl_pkg::S_CMP);
        cmd.ins  = (state_reg == hrsl_pkg::S_APPLY) && advance &&
                   (op_reg == hrsl_pkg::OP_INSERT) && !present && !full;
        cmd.del  = (state_reg == hrsl_pkg::S_APPLY) && advance &&
                   (op_reg == hrsl_pkg::OP_DELETE) && present;
        cmd.hash = key_reg;
        cmd.host = new_host_reg;
    end

    // Cell chain: cell i holds the i-th lowest point
    for (genvar i = 0; i < RING_POINTS; i++)
    begin : g_cell
        logic                          occ;
        logic                          prev_lt;
        logic                          prev_le;
        logic [hrsl_pkg::HASH_W-1:0]   left_hash;
        logic [hrsl_pkg::HOST_W-1:0]   left_host;
        logic [hrsl_pkg::HASH_W-1:0]   right_hash;
        logic [hrsl_pkg::HOST_W-1:0]   right_host;

        assign occ = (count_reg > CW'(i));

        if (i == 0)
        begin : g_first
            // nothing below the first cell: when it shifts on insert, it takes the new point
            assign prev_lt   = 1'b1;
            assign prev_le   = 1'b1;
            assign left_hash = key_reg;
            assign left_host = new_host_reg;
        end
        else
        begin : g_inner
            assign prev_lt   = cell_flags[i-1].lt;
            assign prev_le   = cell_flags[i-1].le;
            assign left_hash = cell_hash[i-1];
            assign left_host = cell_host[i-1];
        end

        if (i == RING_POINTS - 1)
        begin : g_last
            assign right_hash = cell_hash[i];
            assign right_host = cell_host[i];
        end
        else
        begin : g_mid
            assign right_hash = cell_hash[i+1];
            assign right_host = cell_host[i+1];
        end

        hrsl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .occ        (occ),
            .prev_lt    (prev_lt),
            .prev_le    (prev_le),
            .left_hash  (left_hash),
            .left_host  (left_host),
            .right_hash (right_hash),
            .right_host (right_host),
            .hash       (cell_hash[i]),
            .host       (cell_host[i]),
            .flags      (cell_flags[i]),
            .sel        (sel_vec[i])
        );

        assign eq_vec[i] = cell_flags[i].eq;
    end

    // At most one cell flags itself as successor; AND-OR pick of its host
    always_comb
    begin
        sel_host = '0;
        for (int i = 0; i < RING_POINTS; i++)
        begin
            sel_host = sel_host | (cell_host[i] & {hrsl_pkg::HOST_W{sel_vec[i]}});
        end
    end
    assign any_sel = |sel_vec;

    // Result and point count
    always_comb
    begin
        count_next  = count_reg;
        mapped_next = '0;
        status_next = hrsl_pkg::ST_OK;
        case (op_reg)
            hrsl_pkg::OP_INSERT:
            begin
                if (present)
                begin
                    status_next = hrsl_pkg::ST_DUP;
                end
                else if (full)
                begin
                    status_next = hrsl_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            hrsl_pkg::OP_DELETE:
            begin
                if (present)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = hrsl_pkg::ST_ABSENT;
                end
            end
            hrsl_pkg::OP_LOOKUP:
            begin
                if (count_reg == '0)
                begin
                    status_next = hrsl_pkg::ST_EMPTY;
                end
                else if (any_sel)
                begin
                    mapped_next = sel_host;
                end
                else
                begin
                    // key at or past the highest point: wrap to the lowest
                    mapped_next = cell_host[0];
                end
            end
            default:
            begin
                status_next = hrsl_pkg::ST_OK;
            end
        endcase
        held_ext  = {{PW{1'b0}}, count_next};
        held_next = held_ext[PW-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            hrsl_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = hrsl_pkg::S_CMP;
                end
            end
            hrsl_pkg::S_CMP:
            begin
                state_next = hrsl_pkg::S_APPLY;
            end
            hrsl_pkg::S_APPLY:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    state_next     = in_fire ? hrsl_pkg::S_CMP : hrsl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hrsl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hrsl_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if ((state_reg == hrsl_pkg::S_APPLY) && advance)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg       <= opcode;
            key_reg      <= hash_value;
            new_host_reg <= host_number;
        end
        if ((state_reg == hrsl_pkg::S_APPLY) && advance)
        begin
            mapped_reg <= mapped_next;
            status_reg <= status_next;
            held_reg   <= held_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mapped_host = mapped_reg;
    assign status      = status_reg;
    assign points_held = held_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(RING_POINTS))
        else $error("point count above ring size");

    a_cmp_then_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hrsl_pkg::S_CMP) |=> (state_reg == hrsl_pkg::S_APPLY))
        else $error("compare cycle not followed by update");

    a_no_accept_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hrsl_pkg::S_CMP) |-> !in_ready)
        else $error("input taken during compare cycle");

    a_one_successor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hrsl_pkg::S_APPLY) |-> $onehot0(sel_vec))
        else $error("more than one successor cell");

endmodule

>>> sv/hrsl_cell.sv
// One ring cell: holds a point, compares it with the key, shifts with its neighbours.
module hrsl_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hrsl_pkg::cmd_t                cmd,
    input  logic                          occ,
    input  logic                          prev_lt,
    input  logic                          prev_le,
    input  logic [hrsl_pkg::HASH_W-1:0]   left_hash,
    input  logic [hrsl_pkg::HOST_W-1:0]   left_host,
    input  logic [hrsl_pkg::HASH_W-1:0]   right_hash,
    input  logic [hrsl_pkg::HOST_W-1:0]   right_host,
    output logic [hrsl_pkg::HASH_W-1:0]   hash,
    output logic [hrsl_pkg::HOST_W-1:0]   host,
    output hrsl_pkg::flags_t              flags,
    output logic                          sel
);

    logic [hrsl_pkg::HASH_W-1:0] hash_reg;
    logic [hrsl_pkg::HASH_W-1:0] hash_next;
    logic [hrsl_pkg::HOST_W-1:0] host_reg;
    logic [hrsl_pkg::HOST_W-1:0] host_next;
    hrsl_pkg::flags_t            flags_reg;
    hrsl_pkg::flags_t            flags_next;

    always_comb
    begin
        flags_next = flags_reg;
        if (cmd.cmp)
        begin
            flags_next.occ = occ;
            flags_next.lt  = occ && (hash_reg <  cmd.hash);
            flags_next.le  = occ && (hash_reg <= cmd.hash);
            flags_next.eq  = occ && (hash_reg == cmd.hash);
        end
    end

    always_comb
    begin
        hash_next = hash_reg;
        host_next = host_reg;
        if (cmd.ins && !flags_reg.lt)
        begin
            if (prev_lt)
            begin
                hash_next = cmd.hash;
                host_next = cmd.host;
            end
            else
            begin
                hash_next = left_hash;
                host_next = left_host;
            end
        end
        else if (cmd.del && !flags_reg.lt)
        begin
            hash_next = right_hash;
            host_next = right_host;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    // point storage: no reset
    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        host_reg <= host_next;
    end

    assign hash  = hash_reg;
    assign host  = host_reg;
    assign flags = flags_reg;
    // first point strictly above the key
    assign sel   = flags_reg.occ && !flags_reg.le && prev_le;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the hash ring successor lookup block.
`timescale 1ns / 100ps

module tb;

    localparam int RING_POINTS = 512;
    localparam int POOL_SIZE   = 24;

    localparam int HASH_W   = hrsl_pkg::HASH_W;
    localparam int HOST_W   = hrsl_pkg::HOST_W;
    localparam int OPCODE_W = hrsl_pkg::OPCODE_W;
    localparam int STATUS_W = hrsl_pkg::STATUS_W;
    localparam int HELD_W   = hrsl_pkg::HELD_W;

    // Opcode three has no operation behind it; the block must pass it through untouched
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // One expected result beat
    typedef struct packed {
        logic [HOST_W-1:0] host;
        hrsl_pkg::status_t status;
        logic [HELD_W-1:0] held;
    } ring_reply_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OPCODE_W-1:0] opcode;
    logic [HASH_W-1:0]   hash_value;
    logic [HOST_W-1:0]   host_number;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [HOST_W-1:0]   mapped_host;
    logic [STATUS_W-1:0] status;
    logic [HELD_W-1:0]   points_held;

    // Own copy of the ring, kept sorted ascending by hash
    logic [HASH_W-1:0]   ring_hash [RING_POINTS];
    logic [HOST_W-1:0]   ring_host [RING_POINTS];
    int                  ring_count = 0;

    logic [HASH_W-1:0]   key_pool [POOL_SIZE];
    ring_reply_t         replies_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;      // cycles of forced receiver hold-off still to run
    int fault_count   = 0;

    hash_ring_successor_lookup #(
        .RING_POINTS (RING_POINTS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .hash_value  (hash_value),
        .host_number (host_number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mapped_host (mapped_host),
        .status      (status),
        .points_held (points_held)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Forced hold-off counter, loaded by the back-pressure test
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: random stalls, or a solid stall while the hold-off runs
    always @(posedge clk)
    begin
        out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // Applies one operation to the ring copy and returns the beat it should produce.
    // Insert and delete locate the first point not below the hash; lookup the first
    // point strictly above the key, wrapping to the lowest point past the top.
    function automatic ring_reply_t ring_predict(logic [OPCODE_W-1:0] op,
                                                 logic [HASH_W-1:0] h,
                                                 logic [HOST_W-1:0] host);
        ring_reply_t r;
        int          pos;
        int          i;
        r.host = '0;
        r.status = hrsl_pkg::ST_OK;
        pos = 0;
        case (op)
            hrsl_pkg::OP_INSERT:
            begin
                while (pos < ring_count && ring_hash[pos] < h)
                    pos++;
                // duplicate check wins over the full check
                if (pos < ring_count && ring_hash[pos] == h)
                    r.status = hrsl_pkg::ST_DUP;
                else if (ring_count >= RING_POINTS)
                    r.status = hrsl_pkg::ST_FULL;
                else
                begin
                    for (i = ring_count; i > pos; i--)
                    begin
                        ring_hash[i] = ring_hash[i-1];
                        ring_host[i] = ring_host[i-1];
                    end
                    ring_hash[pos] = h;
                    ring_host[pos] = host;
                    ring_count++;
                end
            end
            hrsl_pkg::OP_DELETE:
            begin
                while (pos < ring_count && ring_hash[pos] < h)
                    pos++;
                if (pos < ring_count && ring_hash[pos] == h)
                begin
                    for (i = pos; i < ring_count - 1; i++)
                    begin
                        ring_hash[i] = ring_hash[i+1];
                        ring_host[i] = ring_host[i+1];
                    end
                    ring_count--;
                end
                else
                    r.status = hrsl_pkg::ST_ABSENT;
            end
            hrsl_pkg::OP_LOOKUP:
            begin
                if (ring_count == 0)
                    r.status = hrsl_pkg::ST_EMPTY;
                else
                begin
                    while (pos < ring_count && ring_hash[pos] <= h)
                        pos++;
                    if (pos >= ring_count)
                        pos = 0;
                    r.host = ring_host[pos];
                end
            end
            default: ;      // unused opcode: ring untouched, plain ok result
        endcase
        r.held = ring_count[HELD_W-1:0];
        return r;
    endfunction

    // Offers one input beat, with random idle cycles ahead of it, and records the
    // expected result once the beat is taken. Valid stays high on return so that
    // back-to-back beats need no second assignment in one step.
    task automatic send_beat(logic [OPCODE_W-1:0] op, logic [HASH_W-1:0] h,
                             logic [HOST_W-1:0] host);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        hash_value  <= h;
        host_number <= host;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        replies_due.push_back(ring_predict(op, h, host));
    endtask

    // One random operation. The hash is either a point already on the ring (a
    // neighbour of it for lookups), a value from the shared pool, or fully random.
    task automatic random_ring_op(int ins_pct, int del_pct, int look_pct,
                                  int hit_pct, int pool_pct);
        int                  roll;
        int                  src;
        logic [OPCODE_W-1:0] op;
        logic [HASH_W-1:0]   h;
        roll = $urandom_range(99);
        if (roll < ins_pct)
            op = hrsl_pkg::OP_INSERT;
        else if (roll < ins_pct + del_pct)
            op = hrsl_pkg::OP_DELETE;
        else if (roll < ins_pct + del_pct + look_pct)
            op = hrsl_pkg::OP_LOOKUP;
        else
            op = OP_UNUSED;
        src = $urandom_range(99);
        if (src < hit_pct && ring_count > 0)
        begin
            h = ring_hash[$urandom_range(ring_count - 1)];
            if (op == hrsl_pkg::OP_LOOKUP)
                h = h + $urandom_range(2) - 1;     // just below, on, or just above
        end
        else if (src < hit_pct + pool_pct)
            h = key_pool[$urandom_range(POOL_SIZE - 1)];
        else
            h = $urandom;
        send_beat(op, h, HOST_W'($urandom));
    endtask

    // Hand-picked beats: empty ring, extremes, duplicates, wrap-round, absent delete
    task automatic test_directed();
        send_beat(hrsl_pkg::OP_LOOKUP, 32'h0000_0000, 8'h00);   // lookup on an empty ring
        send_beat(hrsl_pkg::OP_DELETE, 32'h1234_5678, 8'h00);   // delete with nothing held
        send_beat(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);
        send_beat(hrsl_pkg::OP_INSERT, 32'h0000_0000, 8'h00);
        send_beat(hrsl_pkg::OP_INSERT, 32'hFFFF_FFFF, 8'hFF);
        send_beat(hrsl_pkg::OP_INSERT, 32'h8000_0000, 8'hA5);
        send_beat(hrsl_pkg::OP_INSERT, 32'h0000_0000, 8'h5A);   // duplicate, ignored
        send_beat(hrsl_pkg::OP_LOOKUP, 32'h0000_0000, 8'h00);
        send_beat(hrsl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 8'h00);   // past the top, wraps round
        send_beat(hrsl_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 8'h00);
        send_beat(hrsl_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 8'h00);
        send_beat(hrsl_pkg::OP_LOOKUP, 32'h8000_0000, 8'h00);   // equal hash: strictly greater
        send_beat(OP_UNUSED, 32'h8000_0000, 8'h77);
        send_beat(hrsl_pkg::OP_DELETE, 32'h8000_0000, 8'h00);
        send_beat(hrsl_pkg::OP_DELETE, 32'h8000_0000, 8'h00);   // already gone
        send_beat(hrsl_pkg::OP_LOOKUP, 32'h0000_0000, 8'hFF);   // host field ignored on lookup
        send_beat(hrsl_pkg::OP_DELETE, 32'hFFFF_FFFF, 8'hFF);
        send_beat(hrsl_pkg::OP_LOOKUP, 32'h5555_5555, 8'h00);   // single point, wraps to it
        send_beat(hrsl_pkg::OP_DELETE, 32'h0000_0000, 8'h00);
        send_beat(hrsl_pkg::OP_LOOKUP, 32'hAAAA_AAAA, 8'h00);   // empty again
        send_beat(hrsl_pkg::OP_INSERT, 32'h5555_AAAA, 8'h3C);
    endtask

    // Small, busy ring: many hits, duplicates, absent deletes and empty lookups
    task automatic test_random_mixed();
        int n;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < POOL_SIZE; n++)
            key_pool[n] = $urandom;
        for (n = 0; n < 60; n++)
            random_ring_op(40, 28, 28, 35, 35);
    endtask

    // Grows the ring to capacity, then works it at the full boundary
    task automatic test_fill_to_full();
        int n;
        while (ring_count < RING_POINTS)
            random_ring_op(92, 2, 5, 3, 0);
        for (n = 0; n < 6; n++)
            send_beat(hrsl_pkg::OP_INSERT, $urandom, HOST_W'($urandom));  // refused, full
        send_beat(hrsl_pkg::OP_INSERT, ring_hash[0], 8'h11);              // duplicate at full
        send_beat(hrsl_pkg::OP_INSERT, ring_hash[RING_POINTS - 1], 8'h22);
        send_beat(hrsl_pkg::OP_LOOKUP, ring_hash[RING_POINTS - 1], 8'h00); // wraps at full
        for (n = 0; n < 40; n++)
            random_ring_op(40, 20, 35, 40, 0);
    endtask

    // Receiver stalls solidly while the sender keeps offering; the block must fill
    // its result register, hold its input off and then drain without loss.
    task automatic test_backpressure();
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left <= 300;
        for (n = 0; n < 16; n++)
            random_ring_op(35, 25, 35, 50, 20);
    endtask

    // Full rate on both sides over a large ring
    task automatic test_random_no_idle();
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (n = 0; n < 40; n++)
            random_ring_op(30, 30, 35, 45, 20);
    endtask

    // Result checker: every beat taken must match the oldest expectation
    always @(posedge clk)
    begin
        ring_reply_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: result beat with none expected: host %h status %0d held %0d",
                             $realtime, mapped_host, status, points_held);
            end
            else
            begin
                exp_r = replies_due.pop_front();
                if (mapped_host !== exp_r.host || status !== exp_r.status
                    || points_held !== exp_r.held)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: mismatch host %h/%h status %0d/%0d held %0d/%0d",
                                 $realtime, exp_r.host, mapped_host, exp_r.status, status,
                                 exp_r.held, points_held);
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = hrsl_pkg::OP_INSERT;
        hash_value  = '0;
        host_number = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles more lightly than the receiver to begin with
        send_idle_pct = 29;
        recv_idle_pct = 45;
        test_directed();
        test_random_mixed();

        // then the other way round
        send_idle_pct = 45;
        recv_idle_pct = 29;
        test_fill_to_full();

        // no idling from here on
        test_backpressure();
        test_random_no_idle();

        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);     // catch any stray extra result beat

        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
sv/hrsl_pkg.sv
sv/hrsl_cell.sv
sv/hash_ring_successor_lookup.sv
tb/tb.sv
